@@ hw/rtl/battery_soc_kalman_estimator_assert.svh @@
// ----------------------------------------------------------------------------
// battery soc kalman estimator assertion macros
// shared concurrent assertion forms, clocked and disabled during reset
// ----------------------------------------------------------------------------
`ifndef BATTERY_SOC_KALMAN_ESTIMATOR_ASSERT_SVH
`define BATTERY_SOC_KALMAN_ESTIMATOR_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define BSK_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("bsk assertion failed");

// condition holds in the cycle after the trigger
`define BSK_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("bsk assertion failed");

`endif

@@ hw/rtl/bsk_pkg.sv @@
// ----------------------------------------------------------------------------
// bsk_pkg
// types, codes and fixed-point helpers of the battery soc estimator
// ----------------------------------------------------------------------------
package bsk_pkg;

  // q.24 signed fixed point, 40 bits
  typedef logic signed [39:0] q_t;

  localparam q_t QOne     = 40'sd16777216;
  localparam q_t QMax     = {1'b0, {39{1'b1}}};
  localparam q_t QMin     = {1'b1, {39{1'b0}}};
  localparam q_t VarReset = 40'sd83886;

  typedef enum logic [1:0] {
    CMD_SAMPLE     = 2'd0,
    CMD_LOAD_COEFF = 2'd1,
    CMD_SET_SOC    = 2'd2,
    CMD_NOP        = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_RC1_DECAY       = 3'd0,
    CFG_RC2_DECAY       = 3'd1,
    CFG_SOC_PER_CURRENT = 3'd2,
    CFG_RC1_GAIN        = 3'd3,
    CFG_RC2_GAIN        = 3'd4,
    CFG_OHMIC_GAIN      = 3'd5,
    CFG_MEAS_NOISE      = 3'd6,
    CFG_PROC_NOISE      = 3'd7
  } cfg_e;

  typedef struct packed {
    cmd_e       command;
    q_t         current;
    q_t         voltage;
    logic [2:0] coeff_index;
    q_t         load_value;
  } in_t;

  typedef struct packed {
    logic [24:0] soc;
    q_t          voltage_estimate;
    q_t          innovation;
  } out_t;

  // saturate a 41-bit two's complement sum to 40 bits
  function automatic q_t sat41(logic [40:0] s);
    if (s[40] != s[39]) begin
      return s[40] ? QMin : QMax;
    end
    return q_t'(s[39:0]);
  endfunction

  function automatic q_t sat_add(q_t a, q_t b);
    logic [40:0] s;
    s = {a[39], a} + {b[39], b};
    return sat41(s);
  endfunction

  function automatic q_t sat_sub(q_t a, q_t b);
    logic [40:0] s;
    s = {a[39], a} - {b[39], b};
    return sat41(s);
  endfunction

  // magnitude as unsigned, most negative value maps to 2^39
  function automatic logic [39:0] magn(q_t v);
    return v[39] ? 40'(-v) : 40'(v);
  endfunction

  // apply sign to a magnitude and saturate to 40 bits
  function automatic q_t mag_sat(logic [63:0] q, logic neg);
    if (neg) begin
      if (q > 64'h0000_0080_0000_0000) begin
        return QMin;
      end
      return q_t'(-q[39:0]);
    end
    if (q > 64'h0000_007f_ffff_ffff) begin
      return QMax;
    end
    return q_t'(q[39:0]);
  endfunction

  // clamp to the unit range [0, one]
  function automatic q_t clamp_unit(q_t v);
    if (v < 0) begin
      return '0;
    end
    if (v > QOne) begin
      return QOne;
    end
    return v;
  endfunction

endpackage

@@ hw/rtl/bsk_mul.sv @@
// ----------------------------------------------------------------------------
// bsk_mul
// shared q.24 multiplier: 40x20 array over two passes, then round and saturate
// ----------------------------------------------------------------------------
module bsk_mul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  bsk_pkg::q_t   a_i,
  input  bsk_pkg::q_t   b_i,
  output logic          done_o,
  output bsk_pkg::q_t   res_o
);
  import bsk_pkg::*;

  typedef enum logic [3:0] {
    MUL_IDLE = 4'b0001,
    MUL_LO   = 4'b0010,
    MUL_HI   = 4'b0100,
    MUL_OUT  = 4'b1000
  } mul_state_e;

  mul_state_e  state_q, state_d;
  logic [39:0] ma_q, mb_q;
  logic        neg_q;
  logic [79:0] prod_q, prod_d;
  logic [19:0] half;
  logic [59:0] pp;
  logic [79:0] rounded;

  // one partial product per pass
  assign half    = (state_q == MUL_LO) ? mb_q[19:0] : mb_q[39:20];
  assign pp      = ma_q * half;
  assign rounded = prod_q + 80'h80_0000;

  always_comb begin
    state_d = state_q;
    prod_d  = prod_q;
    done_o  = 1'b0;
    res_o   = mag_sat(64'(rounded[79:24]), neg_q);
    unique case (state_q)
      MUL_IDLE: begin
        if (start_i) begin
          state_d = MUL_LO;
        end
      end
      MUL_LO: begin
        prod_d  = 80'(pp);
        state_d = MUL_HI;
      end
      MUL_HI: begin
        prod_d  = prod_q + {pp, 20'b0};
        state_d = MUL_OUT;
      end
      MUL_OUT: begin
        done_o  = 1'b1;
        state_d = MUL_IDLE;
      end
      default: state_d = MUL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MUL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // operand magnitudes and product accumulator
  always_ff @(posedge clk_i) begin
    if (state_q == MUL_IDLE && start_i) begin
      ma_q  <= magn(a_i);
      mb_q  <= magn(b_i);
      neg_q <= a_i[39] ^ b_i[39];
    end
    prod_q <= prod_d;
  end

endmodule

@@ hw/rtl/bsk_div.sv @@
// ----------------------------------------------------------------------------
// bsk_div
// q.24 divider: restoring, one quotient bit per cycle, rounded half away
// ----------------------------------------------------------------------------
module bsk_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  bsk_pkg::q_t   num_i,
  input  bsk_pkg::q_t   den_i,
  output logic          done_o,
  output bsk_pkg::q_t   res_o
);
  import bsk_pkg::*;

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_OUT  = 3'b100
  } div_state_e;

  div_state_e  state_q, state_d;
  logic [63:0] num_q, quo_q;
  logic [39:0] rem_q, md_q;
  logic        neg_q, zero_q;
  logic [5:0]  cnt_q;
  logic [40:0] rem_sh, rem_sub;
  logic        fits;
  logic [39:0] mn_in, md_in;

  assign mn_in   = magn(num_i);
  assign md_in   = magn(den_i);
  assign rem_sh  = {rem_q, num_q[63]};
  assign rem_sub = rem_sh - {1'b0, md_q};
  assign fits    = rem_sh >= {1'b0, md_q};

  always_comb begin
    state_d = state_q;
    done_o  = 1'b0;
    res_o   = zero_q ? '0 : mag_sat(quo_q, neg_q);
    unique case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          state_d = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (cnt_q == 6'd63) begin
          state_d = DIV_OUT;
        end
      end
      DIV_OUT: begin
        done_o  = 1'b1;
        state_d = DIV_IDLE;
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == DIV_RUN) begin
        cnt_q <= cnt_q + 6'd1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  // dividend is n*2^24 plus half the divisor for rounding
  always_ff @(posedge clk_i) begin
    if (state_q == DIV_IDLE && start_i) begin
      num_q  <= {mn_in, 24'b0} + 64'(md_in[39:1]);
      md_q   <= md_in;
      rem_q  <= '0;
      quo_q  <= '0;
      neg_q  <= num_i[39] ^ den_i[39];
      zero_q <= (md_in == '0);
    end else if (state_q == DIV_RUN) begin
      num_q <= {num_q[62:0], 1'b0};
      quo_q <= {quo_q[62:0], fits};
      rem_q <= fits ? rem_sub[39:0] : rem_sh[39:0];
    end
  end

endmodule

@@ hw/rtl/battery_soc_kalman_estimator.sv @@
// ----------------------------------------------------------------------------
// battery_soc_kalman_estimator
// state-of-charge extended kalman filter for a two-rc cell model, q.24
// ----------------------------------------------------------------------------
// usage:
// - input channel (in_valid_i / in_stall_o / in_data_i) takes one command
//   word at a time: sample update, load ocv coefficient, set soc or nop
// - every command returns exactly one word on the output channel
//   (out_valid_o / out_stall_i / out_data_o), held in an output register
// - a sample runs its 2*POLY_TERMS+10 products one after another in the one
//   shared multiplier, and the gain division in the serial divider
// - in_stall_o is high from acceptance until the result enters the output
//   register; while the receiver stalls a waiting word, the next command is
//   still accepted and processed, and only the final step waits for space
// - configuration writes (cfg_valid_i / cfg_ready_o) are always ready and
//   are meant for idle periods
// - reset clears all but the work registers; soc variance restarts at 0.005
// ----------------------------------------------------------------------------
`include "battery_soc_kalman_estimator_assert.svh"

module battery_soc_kalman_estimator #(
  parameter int unsigned POLY_TERMS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bsk_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bsk_pkg::out_t  out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  bsk_pkg::cfg_e  cfg_index_i,
  input  logic [39:0]    cfg_data_i
);
  import bsk_pkg::*;

  localparam int unsigned IdxW  = $clog2(POLY_TERMS);
  localparam int unsigned ProdW = 40 + IdxW + 1;
  localparam logic signed [ProdW-1:0] ProdMax = ProdW'(QMax);
  localparam logic signed [ProdW-1:0] ProdMin = ProdW'(QMin);

  typedef enum logic [14:0] {
    ST_IDLE      = 15'h0001,
    ST_SOC_PRED  = 15'h0002,
    ST_RC1_DECAY = 15'h0004,
    ST_RC1_INPUT = 15'h0008,
    ST_RC2_DECAY = 15'h0010,
    ST_RC2_INPUT = 15'h0020,
    ST_OCV       = 15'h0040,
    ST_OHMIC     = 15'h0080,
    ST_SLOPE     = 15'h0100,
    ST_PH        = 15'h0200,
    ST_INNOV_VAR = 15'h0400,
    ST_GAIN      = 15'h0800,
    ST_SOC_CORR  = 15'h1000,
    ST_KH        = 15'h2000,
    ST_VAR       = 15'h4000
  } state_e;

  // result transfer is the last step, folded into idle-bound states
  localparam state_e ST_RESP = ST_IDLE;

  // configuration registers
  q_t          rc1_decay_q, rc2_decay_q, soc_per_cur_q;
  q_t          rc1_gain_q, rc2_gain_q, ohmic_gain_q;
  logic [38:0] meas_noise_q, proc_noise_q;

  // filter state
  q_t soc_q, soc_d, rc1_q, rc1_d, rc2_q, rc2_d, var_q, var_d;
  q_t coef_q [POLY_TERMS];

  // sequencer and work registers
  state_e         state_q, state_d;
  logic           issued_q, issued_d, resp_q, resp_d;
  logic           out_valid_q, out_valid_d;
  out_t           out_q, out_d;
  logic [IdxW-1:0] idx_q, idx_d;
  q_t cur_q, cur_d, vm_q, vm_d, acc_q, acc_d, ct_q, ct_d, tmp_q, tmp_d;
  q_t vp_q, vp_d, innov_q, innov_d, h_q, h_d, ph_q, ph_d, k_q, k_d;

  // shared units
  logic mul_start, mul_done, div_start, div_done;
  q_t   mul_a, mul_b, mul_res, div_res;

  logic [IdxW-1:0]          slope_k;
  logic signed [ProdW-1:0]  slope_prod;
  q_t                       slope_coef;
  logic [4:0]               load_idx;
  logic                     in_accept;

  assign in_stall_o  = (state_q != ST_IDLE) || resp_q;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;
  assign load_idx    = 5'(in_data_i.coeff_index);

  bsk_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  bsk_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (ph_q),
    .den_i   (tmp_q),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  // derivative coefficient: (terms-1-i) times coefficient i, saturated
  assign slope_k    = IdxW'(POLY_TERMS - 1) - idx_q;
  assign slope_prod = $signed(coef_q[idx_q]) * $signed({1'b0, slope_k});
  always_comb begin
    if (slope_prod > ProdMax) begin
      slope_coef = QMax;
    end else if (slope_prod < ProdMin) begin
      slope_coef = QMin;
    end else begin
      slope_coef = q_t'(slope_prod[39:0]);
    end
  end

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SOC_PRED:  begin mul_a = cur_q;   mul_b = soc_per_cur_q; end
      ST_RC1_DECAY: begin mul_a = rc1_q;   mul_b = rc1_decay_q;   end
      ST_RC1_INPUT: begin mul_a = cur_q;   mul_b = rc1_gain_q;    end
      ST_RC2_DECAY: begin mul_a = rc2_q;   mul_b = rc2_decay_q;   end
      ST_RC2_INPUT: begin mul_a = cur_q;   mul_b = rc2_gain_q;    end
      ST_OCV:       begin mul_a = acc_q;   mul_b = soc_q;         end
      ST_SLOPE:     begin mul_a = acc_q;   mul_b = soc_q;         end
      ST_OHMIC:     begin mul_a = cur_q;   mul_b = ohmic_gain_q;  end
      ST_PH:        begin mul_a = var_q;   mul_b = h_q;           end
      ST_INNOV_VAR: begin mul_a = ph_q;    mul_b = h_q;           end
      ST_SOC_CORR:  begin mul_a = k_q;     mul_b = innov_q;       end
      ST_KH:        begin mul_a = k_q;     mul_b = h_q;           end
      ST_VAR:       begin mul_a = tmp_q;   mul_b = var_q;         end
      default:      begin mul_a = '0;      mul_b = '0;            end
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    issued_d    = issued_q;
    resp_d      = resp_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    idx_d       = idx_q;
    soc_d = soc_q;  rc1_d = rc1_q;  rc2_d = rc2_q;  var_d = var_q;
    cur_d = cur_q;  vm_d = vm_q;    acc_d = acc_q;  ct_d = ct_q;
    tmp_d = tmp_q;  vp_d = vp_q;    innov_d = innov_q;
    h_d = h_q;      ph_d = ph_q;    k_d = k_q;
    mul_start   = 1'b0;
    div_start   = 1'b0;

    // output word taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (resp_q) begin
          // move the result into the output register once it has room
          if (!out_valid_q || !out_stall_i) begin
            out_d       = '{soc: soc_q[24:0], voltage_estimate: vp_q,
                            innovation: innov_q};
            out_valid_d = 1'b1;
            resp_d      = 1'b0;
          end
        end else if (in_valid_i) begin
          cur_d   = in_data_i.current;
          vm_d    = in_data_i.voltage;
          vp_d    = '0;
          innov_d = '0;
          unique case (in_data_i.command)
            CMD_SAMPLE:  state_d = ST_SOC_PRED;
            CMD_SET_SOC: begin
              soc_d  = clamp_unit(in_data_i.load_value);
              resp_d = 1'b1;
            end
            default:     resp_d = 1'b1;
          endcase
        end
      end
      default: begin
        // every other state issues one operation and waits for it
        if (!issued_q) begin
          issued_d = 1'b1;
          if (state_q == ST_GAIN) begin
            div_start = 1'b1;
          end else begin
            mul_start = 1'b1;
          end
          if (state_q == ST_OCV) begin
            ct_d = coef_q[idx_q];
          end
          if (state_q == ST_SLOPE) begin
            ct_d    = slope_coef;
            innov_d = sat_sub(vm_q, vp_q);
          end
          if (state_q == ST_OHMIC) begin
            vp_d = sat_sub(sat_sub(acc_q, rc1_q), rc2_q);
          end
        end else if (mul_done || div_done) begin
          issued_d = 1'b0;
          unique case (state_q)
            ST_SOC_PRED: begin
              soc_d   = sat_add(soc_q, mul_res);
              state_d = ST_RC1_DECAY;
            end
            ST_RC1_DECAY: begin
              tmp_d   = mul_res;
              state_d = ST_RC1_INPUT;
            end
            ST_RC1_INPUT: begin
              rc1_d   = sat_add(tmp_q, mul_res);
              state_d = ST_RC2_DECAY;
            end
            ST_RC2_DECAY: begin
              tmp_d   = mul_res;
              state_d = ST_RC2_INPUT;
            end
            ST_RC2_INPUT: begin
              rc2_d   = sat_add(tmp_q, mul_res);
              var_d   = sat_add(var_q, q_t'({1'b0, proc_noise_q}));
              acc_d   = '0;
              idx_d   = '0;
              state_d = ST_OCV;
            end
            ST_OCV: begin
              acc_d = sat_add(mul_res, ct_q);
              if (idx_q == IdxW'(POLY_TERMS - 1)) begin
                state_d = ST_OHMIC;
              end else begin
                idx_d = idx_q + 1'b1;
              end
            end
            ST_OHMIC: begin
              vp_d    = sat_sub(vp_q, mul_res);
              acc_d   = '0;
              idx_d   = '0;
              state_d = ST_SLOPE;
            end
            ST_SLOPE: begin
              acc_d = sat_add(mul_res, ct_q);
              if (idx_q == IdxW'(POLY_TERMS - 2)) begin
                h_d     = sat_add(mul_res, ct_q);
                state_d = ST_PH;
              end else begin
                idx_d = idx_q + 1'b1;
              end
            end
            ST_PH: begin
              ph_d    = mul_res;
              state_d = ST_INNOV_VAR;
            end
            ST_INNOV_VAR: begin
              tmp_d   = sat_add(mul_res, q_t'({1'b0, meas_noise_q}));
              state_d = ST_GAIN;
            end
            ST_GAIN: begin
              k_d     = div_res;
              state_d = ST_SOC_CORR;
            end
            ST_SOC_CORR: begin
              soc_d   = sat_add(soc_q, mul_res);
              state_d = ST_KH;
            end
            ST_KH: begin
              tmp_d   = sat_sub(QOne, mul_res);
              state_d = ST_VAR;
            end
            ST_VAR: begin
              var_d   = mul_res;
              soc_d   = clamp_unit(soc_q);
              resp_d  = 1'b1;
              state_d = ST_RESP;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      resp_q      <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      resp_q      <= resp_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      soc_q <= '0;
      rc1_q <= '0;
      rc2_q <= '0;
      var_q <= VarReset;
    end else begin
      soc_q <= soc_d;
      rc1_q <= rc1_d;
      rc2_q <= rc2_d;
      var_q <= var_d;
    end
  end

  // ocv coefficients, loads beyond the polynomial length are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < POLY_TERMS; i++) begin
        coef_q[i] <= '0;
      end
    end else if (in_accept && in_data_i.command == CMD_LOAD_COEFF &&
                 load_idx < 5'(POLY_TERMS)) begin
      coef_q[load_idx[IdxW-1:0]] <= in_data_i.load_value;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc1_decay_q   <= '0;
      rc2_decay_q   <= '0;
      soc_per_cur_q <= '0;
      rc1_gain_q    <= '0;
      rc2_gain_q    <= '0;
      ohmic_gain_q  <= '0;
      meas_noise_q  <= '0;
      proc_noise_q  <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_RC1_DECAY:       rc1_decay_q   <= cfg_data_i;
        CFG_RC2_DECAY:       rc2_decay_q   <= cfg_data_i;
        CFG_SOC_PER_CURRENT: soc_per_cur_q <= cfg_data_i;
        CFG_RC1_GAIN:        rc1_gain_q    <= cfg_data_i;
        CFG_RC2_GAIN:        rc2_gain_q    <= cfg_data_i;
        CFG_OHMIC_GAIN:      ohmic_gain_q  <= cfg_data_i;
        CFG_MEAS_NOISE:      meas_noise_q  <= cfg_data_i[38:0];
        CFG_PROC_NOISE:      proc_noise_q  <= cfg_data_i[38:0];
        default:             ;
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    vm_q    <= vm_d;
    acc_q   <= acc_d;
    ct_q    <= ct_d;
    tmp_q   <= tmp_d;
    vp_q    <= vp_d;
    innov_q <= innov_d;
    h_q     <= h_d;
    ph_q    <= ph_d;
    k_q     <= k_d;
    out_q   <= out_d;
  end

  // checks
  `BSK_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_accept, in_stall_o)
  `BSK_ASSERT_NOW(a_soc_range, clk_i, rst_ni, state_q == ST_IDLE, !soc_q[39] && soc_q <= QOne)
  `BSK_ASSERT_NOW(a_unit_owned, clk_i, rst_ni, mul_done || div_done, issued_q)
  `BSK_ASSERT_NEXT(a_resp_out, clk_i, rst_ni, resp_q && (!out_valid_q || !out_stall_i), out_valid_q)

endmodule

@@ tb/sv/battery_soc_kalman_estimator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// battery_soc_kalman_estimator_tb
// drives commands into the soc estimator and checks every result word
// against an in-bench fixed-point model of the kalman filter, across several
// register settings, with random idling on both channels and a long output
// hold-off that backs the block up
// ----------------------------------------------------------------------------
module battery_soc_kalman_estimator_tb;
  import bsk_pkg::*;

  localparam int NTERMS = 8;
  localparam logic signed [63:0] MAXV = 64'sd549755813887;
  localparam logic signed [63:0] MINV = -64'sd549755813888;
  localparam logic signed [63:0] ONEV = 64'sd16777216;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  in_t   in_data_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  out_t  out_data_o;
  logic  cfg_valid_i = 1'b0;
  logic  cfg_ready_o;
  cfg_e  cfg_index_i = CFG_RC1_DECAY;
  logic [39:0] cfg_data_i = '0;

  battery_soc_kalman_estimator #(.POLY_TERMS(NTERMS)) u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // estimator copy: registers and state as 64-bit signed
  logic signed [63:0] est_cfg [8];
  logic signed [63:0] est_soc, est_rc1, est_rc2, est_var;
  logic signed [63:0] est_coef [NTERMS];

  in_t  cmd_queue [$];
  out_t soc_expected [$];
  int   n_errors = 0;
  bit   calm = 1'b0;      // no idling stretch
  bit   holdoff = 1'b0;   // long receiver hold-off request
  int   hold_cnt = 0;

  function automatic logic signed [63:0] sat(logic signed [63:0] v);
    if (v > MAXV) return MAXV;
    if (v < MINV) return MINV;
    return v;
  endfunction

  function automatic logic signed [63:0] sat_mag(logic [127:0] q, bit neg);
    if (neg) return (q > 128'd549755813888) ? MINV : -$signed({1'b0, q[62:0]});
    return (q > 128'd549755813887) ? MAXV : $signed({1'b0, q[62:0]});
  endfunction

  function automatic logic [127:0] mag(logic signed [63:0] v);
    return v < 0 ? 128'(-v) : 128'(v);
  endfunction

  // product shifted by 24, rounded half away from zero
  function automatic logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
    logic [127:0] p;
    p = (mag(a) * mag(b) + (128'd1 << 23)) >> 24;
    return sat_mag(p, (a < 0) != (b < 0));
  endfunction

  function automatic logic signed [63:0] qdiv(logic signed [63:0] n, logic signed [63:0] d);
    logic [127:0] q;
    if (d == 0) return 0;
    q = ((mag(n) << 24) + mag(d) / 2) / mag(d);
    return sat_mag(q, (n < 0) != (d < 0));
  endfunction

  function automatic logic signed [63:0] ocv_poly(int terms, bit deriv, logic signed [63:0] x);
    logic signed [63:0] s, c;
    s = 0;
    for (int i = 0; i < terms; i++) begin
      c = est_coef[i];
      if (deriv) c = sat(c * (NTERMS - 1 - i));
      s = sat(qmul(s, x) + c);
    end
    return s;
  endfunction

  function automatic out_t estimate_step(in_t w);
    logic signed [63:0] cur, vm, vp, innov, h, ph, s, k, v;
    out_t r;
    vp = 0;
    innov = 0;
    case (w.command)
      CMD_SAMPLE: begin
        cur = w.current;
        vm = w.voltage;
        est_soc = sat(est_soc + qmul(cur, est_cfg[CFG_SOC_PER_CURRENT]));
        est_rc1 = sat(qmul(est_rc1, est_cfg[CFG_RC1_DECAY]) + qmul(cur, est_cfg[CFG_RC1_GAIN]));
        est_rc2 = sat(qmul(est_rc2, est_cfg[CFG_RC2_DECAY]) + qmul(cur, est_cfg[CFG_RC2_GAIN]));
        est_var = sat(est_var + est_cfg[CFG_PROC_NOISE]);
        vp = ocv_poly(NTERMS, 1'b0, est_soc);
        vp = sat(vp - est_rc1);
        vp = sat(vp - est_rc2);
        vp = sat(vp - qmul(cur, est_cfg[CFG_OHMIC_GAIN]));
        innov = sat(vm - vp);
        h = ocv_poly(NTERMS - 1, 1'b1, est_soc);
        ph = qmul(est_var, h);
        s = sat(qmul(ph, h) + est_cfg[CFG_MEAS_NOISE]);
        k = qdiv(ph, s);
        est_soc = sat(est_soc + qmul(k, innov));
        est_var = qmul(sat(ONEV - qmul(k, h)), est_var);
        if (est_soc < 0) est_soc = 0;
        if (est_soc > ONEV) est_soc = ONEV;
      end
      CMD_LOAD_COEFF: if (w.coeff_index < NTERMS) est_coef[w.coeff_index] = w.load_value;
      CMD_SET_SOC: begin
        v = w.load_value;
        if (v < 0) v = 0;
        if (v > ONEV) v = ONEV;
        est_soc = v;
      end
      default: ;
    endcase
    r.soc = est_soc[24:0];
    r.voltage_estimate = vp[39:0];
    r.innovation = innov[39:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // driver: one word from the queue at a time
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (cmd_queue.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
          in_data_i <= cmd_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // predict at acceptance
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) soc_expected.push_back(estimate_step(in_data_i));
  end

  // receiver stall, with a counted long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (holdoff && hold_cnt == 0) hold_cnt <= 400;
      if (hold_cnt > 1) out_stall_i <= 1'b1;
      else out_stall_i <= !calm && ($urandom_range(99) < 19);
      if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (soc_expected.size() == 0) begin
        report_mismatch("unexpected word", 40'(out_data_o.soc), 40'd0);
      end else begin
        want = soc_expected.pop_front();
        if (out_data_o.soc !== want.soc) report_mismatch("soc", 40'(out_data_o.soc), 40'(want.soc));
        if (out_data_o.voltage_estimate !== want.voltage_estimate)
          report_mismatch("voltage_estimate", out_data_o.voltage_estimate, want.voltage_estimate);
        if (out_data_o.innovation !== want.innovation)
          report_mismatch("innovation", out_data_o.innovation, want.innovation);
      end
    end
  end

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || in_valid_i || soc_expected.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, logic [39:0] val);
    @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_MEAS_NOISE || idx == CFG_PROC_NOISE) est_cfg[idx] = {25'd0, val[38:0]};
    else est_cfg[idx] = $signed(val);
  endtask

  function automatic logic [39:0] rnd40();
    return 40'({$urandom, $urandom});
  endfunction

  function automatic logic [39:0] near(logic [39:0] base, int span);
    return base + 40'($signed($urandom_range(2 * span)) - span);
  endfunction

  task automatic push(cmd_e c, logic [39:0] cur, logic [39:0] vol, logic [2:0] ix,
                      logic [39:0] lv);
    in_t w;
    w.command = c;
    w.current = cur;
    w.voltage = vol;
    w.coeff_index = ix;
    w.load_value = lv;
    cmd_queue.push_back(w);
  endtask

  // realistic battery setting: decays near one, small gains
  task automatic load_plant();
    write_reg(CFG_RC1_DECAY, 40'd16600000);
    write_reg(CFG_RC2_DECAY, 40'd16770000);
    write_reg(CFG_SOC_PER_CURRENT, -40'sd4660);
    write_reg(CFG_RC1_GAIN, 40'd3000);
    write_reg(CFG_RC2_GAIN, 40'd800);
    write_reg(CFG_OHMIC_GAIN, 40'd335544);
    write_reg(CFG_MEAS_NOISE, 40'd16777);
    write_reg(CFG_PROC_NOISE, 40'd17);
  endtask

  task automatic random_phase(int n, bit wild);
    for (int i = 0; i < n; i++) begin
      int r;
      r = $urandom_range(99);
      if (r < 5) push(CMD_LOAD_COEFF, rnd40(), rnd40(), 3'($urandom),
                      wild ? rnd40() : near(40'd0, 30000000));
      else if (r < 9) push(CMD_SET_SOC, rnd40(), rnd40(), 3'($urandom),
                           ($urandom_range(3) == 0) ? rnd40() : 40'($urandom_range(16777216)));
      else if (r < 11) push(CMD_NOP, rnd40(), rnd40(), 3'($urandom), rnd40());
      else if (wild || r < 20) push(CMD_SAMPLE, rnd40(), rnd40(), 3'($urandom), rnd40());
      else push(CMD_SAMPLE, near(40'd0, 200000000), near(40'd62914560, 30000000),
                3'($urandom), rnd40());
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) est_cfg[i] = 0;
    for (int i = 0; i < NTERMS; i++) est_coef[i] = 0;
    est_soc = 0;
    est_rc1 = 0;
    est_rc2 = 0;
    est_var = 83886;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset-state sample, coefficient loads, soc extremes, all commands
    push(CMD_SAMPLE, 40'd0, 40'd0, 3'd0, 40'd0);
    push(CMD_NOP, 40'hff_ffff_ffff, 40'hff_ffff_ffff, 3'd7, 40'hff_ffff_ffff);
    push(CMD_SET_SOC, 40'd0, 40'd0, 3'd0, 40'h80_0000_0000);
    push(CMD_SET_SOC, 40'd0, 40'd0, 3'd0, 40'h7f_ffff_ffff);
    push(CMD_SET_SOC, 40'd0, 40'd0, 3'd0, 40'd16777217);
    push(CMD_SET_SOC, 40'd0, 40'd0, 3'd0, 40'd8388608);
    push(CMD_LOAD_COEFF, 40'd0, 40'd0, 3'd5, 40'd8388608);
    push(CMD_LOAD_COEFF, 40'd0, 40'd0, 3'd6, 40'd16777216);
    push(CMD_LOAD_COEFF, 40'd0, 40'd0, 3'd7, 40'd58720256);
    push(CMD_SAMPLE, 40'd16777216, 40'd62914560, 3'd0, 40'd0);
    push(CMD_SAMPLE, 40'h7f_ffff_ffff, 40'h80_0000_0000, 3'd0, 40'd0);
    push(CMD_SAMPLE, 40'h80_0000_0000, 40'h7f_ffff_ffff, 3'd0, 40'd0);
    push(CMD_LOAD_COEFF, 40'd0, 40'd0, 3'd0, 40'h7f_ffff_ffff);
    push(CMD_SAMPLE, -40'sd16777216, 40'd0, 3'd0, 40'd0);
    push(CMD_LOAD_COEFF, 40'd0, 40'd0, 3'd0, 40'h80_0000_0000);
    push(CMD_SAMPLE, 40'd0, 40'h7f_ffff_ffff, 3'd0, 40'd0);
    push(CMD_LOAD_COEFF, 40'd0, 40'd0, 3'd0, 40'd0);
    wait_drained();

    // typical cell, with the long hold-off while the sender keeps offering
    load_plant();
    for (int i = 0; i < 8; i++) push(CMD_LOAD_COEFF, '0, '0, 3'(i), near(40'd0, 20000000));
    push(CMD_SET_SOC, '0, '0, '0, 40'd12000000);
    random_phase(30, 1'b0);
    holdoff = 1'b1;
    wait (hold_cnt != 0);
    holdoff = 1'b0;
    random_phase(370, 1'b0);
    wait_drained();

    // extremes on every register, with random words
    write_reg(CFG_RC1_DECAY, 40'h7f_ffff_ffff);
    write_reg(CFG_RC2_DECAY, 40'h80_0000_0000);
    write_reg(CFG_SOC_PER_CURRENT, 40'h7f_ffff_ffff);
    write_reg(CFG_RC1_GAIN, 40'h80_0000_0000);
    write_reg(CFG_RC2_GAIN, 40'h7f_ffff_ffff);
    write_reg(CFG_OHMIC_GAIN, 40'h80_0000_0000);
    write_reg(CFG_MEAS_NOISE, 40'h7f_ffff_ffff);
    write_reg(CFG_PROC_NOISE, 40'h7f_ffff_ffff);
    random_phase(150, 1'b1);
    wait_drained();

    // random register values, a calm stretch without idling
    for (int i = 0; i < 8; i++) write_reg(cfg_e'(i), rnd40());
    calm = 1'b1;
    random_phase(250, 1'b0);
    wait_drained();
    calm = 1'b0;

    // zero noise so the innovation variance can vanish, then back to a plant
    for (int i = 0; i < 8; i++) write_reg(cfg_e'(i), '0);
    random_phase(100, 1'b0);
    wait_drained();
    load_plant();
    random_phase(300, 1'b0);
    wait_drained();

    if (n_errors == 0) begin
      $display("battery_soc_kalman_estimator verification clean");
    end else begin
      $display("battery_soc_kalman_estimator verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #8000000;
    $display("battery_soc_kalman_estimator verification failed");
    $finish;
  end

endmodule
